/* rtl/core/teds_pkg.sv */
`timescale 1ns / 1ps
package teds_pkg;

    // Header byte fields
    localparam int unsigned LenCodeBits  = 3;
    localparam int unsigned TypeCodeBits = 5;

    // Length codes that pull in extended length bytes
    localparam logic [2:0] LenCodeExt8  = 3'd6;
    localparam logic [2:0] LenCodeExt16 = 3'd7;

    // Type codes that pull in extended type bytes
    localparam logic [4:0] TypeCodeExt8  = 5'd30;
    localparam logic [4:0] TypeCodeExt16 = 5'd31;

    // Number of payload bytes packed into the element value
    localparam int unsigned ValueBytes = 8;

    // Result kinds
    localparam logic KindHeader  = 1'b0;
    localparam logic KindPayload = 1'b1;

    // Parser phases
    typedef enum logic [5:0] {
        PH_HDR  = 6'b000001,
        PH_LEN0 = 6'b000010,
        PH_LEN1 = 6'b000100,
        PH_TYP0 = 6'b001000,
        PH_TYP1 = 6'b010000,
        PH_PAY  = 6'b100000
    } t_phase;

    // One result item
    typedef struct packed {
        logic        kind;
        logic [15:0] elem_type;
        logic [15:0] elem_len;
        logic [7:0]  payload_byte;
        logic [15:0] byte_index;
        logic        element_done;
        logic [63:0] element_value;
        logic        cut_short;
    } t_result;

    // Short length codes to payload byte counts
    function automatic logic [15:0] len_from_code(input logic [2:0] code);
        logic [15:0] len;
        case (code)
            3'd0:    len = 16'd0;
            3'd1:    len = 16'd1;
            3'd2:    len = 16'd2;
            3'd3:    len = 16'd4;
            3'd4:    len = 16'd6;
            3'd5:    len = 16'd8;
            default: len = 16'd0;
        endcase
        return len;
    endfunction

endpackage

/* rtl/core/teds_parser.sv */
`timescale 1ns / 1ps
module teds_parser
    import teds_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_data_byte,
    input  logic       i_packet_last,
    output logic       o_res_valid,
    output t_result    o_res
);

    t_phase      r_phase,  n_phase;
    logic [2:0]  r_lcode,  n_lcode;
    logic [4:0]  r_tcode,  n_tcode;
    logic [15:0] r_len,    n_len;
    logic [15:0] r_type,   n_type;
    logic [15:0] r_count,  n_count;
    logic [63:0] r_acc,    n_acc;

    logic        do_after;
    logic        do_done;
    logic        pay_done;
    logic [16:0] idx_next;

    // Decode one byte against the current phase
    always_comb begin
        n_phase  = r_phase;
        n_lcode  = r_lcode;
        n_tcode  = r_tcode;
        n_len    = r_len;
        n_type   = r_type;
        n_count  = r_count;
        n_acc    = r_acc;
        do_after = 1'b0;
        do_done  = 1'b0;
        pay_done = 1'b0;
        idx_next = {1'b0, r_count} + 17'd1;

        o_res_valid         = 1'b0;
        o_res.kind          = KindHeader;
        o_res.payload_byte  = 8'd0;
        o_res.byte_index    = 16'd0;
        o_res.element_done  = 1'b0;
        o_res.element_value = 64'd0;
        o_res.cut_short     = 1'b0;

        case (r_phase)
            PH_LEN0: begin
                n_len = {8'd0, i_data_byte};
                if (r_lcode == LenCodeExt16) begin
                    n_phase = PH_LEN1;
                    if (i_packet_last) begin
                        o_res_valid     = 1'b1;
                        o_res.cut_short = 1'b1;
                        n_phase         = PH_HDR;
                    end
                end else begin
                    do_after = 1'b1;
                end
            end
            PH_LEN1: begin
                n_len    = {i_data_byte, r_len[7:0]};
                do_after = 1'b1;
            end
            PH_TYP0: begin
                n_type = {8'd0, i_data_byte};
                if (r_tcode == TypeCodeExt16) begin
                    n_phase = PH_TYP1;
                    if (i_packet_last) begin
                        o_res_valid     = 1'b1;
                        o_res.cut_short = 1'b1;
                        n_phase         = PH_HDR;
                    end
                end else begin
                    do_done = 1'b1;
                end
            end
            PH_TYP1: begin
                n_type  = {i_data_byte, r_type[7:0]};
                do_done = 1'b1;
            end
            PH_PAY: begin
                // Drop the byte into its lane of the value while inside the first eight
                for (int k = 0; k < ValueBytes; k++) begin
                    if (r_count[15:3] == 13'd0 && r_count[2:0] == 3'(k)) begin
                        n_acc[8*k +: 8] = i_data_byte;
                    end
                end
                pay_done            = idx_next >= {1'b0, r_len};
                o_res_valid         = 1'b1;
                o_res.kind          = KindPayload;
                o_res.payload_byte  = i_data_byte;
                o_res.byte_index    = r_count;
                o_res.element_done  = pay_done;
                o_res.element_value = pay_done ? n_acc : 64'd0;
                o_res.cut_short     = i_packet_last & ~pay_done;
                n_count             = idx_next[15:0];
                if (pay_done || i_packet_last) begin
                    n_phase = PH_HDR;
                end
            end
            default: begin
                // Header byte: length code on top, type code below
                n_lcode = i_data_byte[TypeCodeBits +: LenCodeBits];
                n_tcode = i_data_byte[TypeCodeBits-1:0];
                n_len   = len_from_code(n_lcode);
                n_type  = (n_tcode < TypeCodeExt8) ? {11'd0, n_tcode} : 16'd0;
                n_count = 16'd0;
                n_acc   = 64'd0;
                if (n_lcode >= LenCodeExt8) begin
                    n_phase = PH_LEN0;
                    if (i_packet_last) begin
                        o_res_valid     = 1'b1;
                        o_res.cut_short = 1'b1;
                        n_phase         = PH_HDR;
                    end
                end else begin
                    do_after = 1'b1;
                end
            end
        endcase

        // Length part finished: fetch type bytes or close the header
        if (do_after) begin
            if (n_tcode >= TypeCodeExt8) begin
                n_phase = PH_TYP0;
                if (i_packet_last) begin
                    o_res_valid     = 1'b1;
                    o_res.cut_short = 1'b1;
                    n_phase         = PH_HDR;
                end
            end else begin
                do_done = 1'b1;
            end
        end

        // Header complete: report it and open the payload if it has one and the packet goes on
        if (do_done) begin
            n_count     = 16'd0;
            n_acc       = 64'd0;
            o_res_valid = 1'b1;
            if (n_len == 16'd0) begin
                o_res.element_done = 1'b1;
                n_phase            = PH_HDR;
            end else begin
                o_res.cut_short = i_packet_last;
                n_phase         = i_packet_last ? PH_HDR : PH_PAY;
            end
        end

        o_res.elem_type = n_type;
        o_res.elem_len  = n_len;
    end

    // Advance parser state on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HDR;
            r_lcode <= '0;
            r_tcode <= '0;
            r_len   <= '0;
            r_type  <= '0;
            r_count <= '0;
            r_acc   <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_lcode <= n_lcode;
            r_tcode <= n_tcode;
            r_len   <= n_len;
            r_type  <= n_type;
            r_count <= n_count;
            r_acc   <= n_acc;
        end
    end

endmodule

/* rtl/core/typed_element_stream_deframer_core.sv */
`timescale 1ns / 1ps
// Typed element stream deframer.
// Input channel: one packet byte per item on i_data_byte, with i_packet_last
// marking the final byte of a packet; taken when i_in_valid is high and
// o_in_stall is low.
// Output channel: at most one result item per input item, presented on
// o_out_valid and taken when i_out_stall is low. Header results carry the
// decoded type and length; payload results carry the byte, its index, and
// on the element's last byte the little-endian value of its first eight
// bytes. Extended length or type bytes that do not finish a header give no
// result unless the packet ends on them.
// Results are registered in the output register, or in the skid entry when it is full.
// Throughput: one byte per cycle while o_in_stall is low; the parser state updates in a single pass.
// Stall: an output register plus one skid entry hold results; o_in_stall
// rises only when both are full, so input keeps flowing while only the
// output register is full.
// Reset: synchronous, active low; the parser expects a header byte and all
// held results are dropped.
module typed_element_stream_deframer_core
    import teds_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_packet_last,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_kind,
    output logic [15:0] o_elem_type,
    output logic [15:0] o_elem_len,
    output logic [7:0]  o_payload_byte,
    output logic [15:0] o_byte_index,
    output logic        o_element_done,
    output logic [63:0] o_element_value,
    output logic        o_cut_short
);

    logic    in_fire;
    logic    out_fire;
    logic    res_valid;
    t_result res;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;

    assign o_in_stall = r_skid_valid;
    assign in_fire    = i_in_valid & ~r_skid_valid;
    assign out_fire   = r_out_valid & ~i_out_stall;

    teds_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (in_fire),
        .i_data_byte   (i_data_byte),
        .i_packet_last (i_packet_last),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    // Hold results in the output register, overflow into the skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (out_fire || !r_out_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end
            end else if (in_fire && res_valid) begin
                if (out_fire || !r_out_valid) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (out_fire) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Move payload alongside the valid bits
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_fire || !r_out_valid) begin
                r_out <= r_skid;
            end
        end else if (in_fire && res_valid) begin
            if (out_fire || !r_out_valid) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_out.kind;
    assign o_elem_type     = r_out.elem_type;
    assign o_elem_len      = r_out.elem_len;
    assign o_payload_byte  = r_out.payload_byte;
    assign o_byte_index    = r_out.byte_index;
    assign o_element_done  = r_out.element_done;
    assign o_element_value = r_out.element_value;
    assign o_cut_short     = r_out.cut_short;

endmodule

/* tb/deframer_result_checker.sv */
`timescale 1ns / 1ps
module deframer_result_checker
    import teds_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_packet_last,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic        i_kind,
    input  logic [15:0] i_elem_type,
    input  logic [15:0] i_elem_len,
    input  logic [7:0]  i_payload_byte,
    input  logic [15:0] i_byte_index,
    input  logic        i_element_done,
    input  logic [63:0] i_element_value,
    input  logic        i_cut_short,
    output int unsigned o_mismatch_count,
    output int unsigned o_pending
);

    // Parser state mirrored from the byte stream
    t_phase      phase;
    logic [2:0]  len_code;
    logic [4:0]  typ_code;
    logic [15:0] elem_len;
    logic [15:0] elem_type;
    logic [15:0] pay_count;
    logic [63:0] value_acc;

    t_result     expected_results[$];
    int unsigned mismatches = 0;

    // Header result built from what has been decoded so far
    function automatic t_result header_result(input logic done, input logic cut);
        t_result r;
        r = '0;
        r.kind         = KindHeader;
        r.elem_type    = elem_type;
        r.elem_len     = elem_len;
        r.element_done = done;
        r.cut_short    = cut;
        return r;
    endfunction

    task automatic show_result(input string tag, input t_result r);
        $display("%s kind=%0b type=%h len=%h byte=%h index=%h done=%0b value=%h cut=%0b",
                 tag, r.kind, r.elem_type, r.elem_len, r.payload_byte, r.byte_index,
                 r.element_done, r.element_value, r.cut_short);
    endtask

    // Advance the parser by one byte and queue the result it causes, if any
    task automatic decode_byte(input logic [7:0] b, input logic last);
        logic    length_ready;
        logic    header_ready;
        logic    header_cut;
        logic    done;
        t_result r;
        length_ready = 1'b0;
        header_ready = 1'b0;
        header_cut   = 1'b0;
        case (phase)
            PH_LEN0: begin
                elem_len = {8'h00, b};
                if (len_code == LenCodeExt16) begin
                    phase      = PH_LEN1;
                    header_cut = last;
                end else begin
                    length_ready = 1'b1;
                end
            end
            PH_LEN1: begin
                elem_len[15:8] = b;
                length_ready   = 1'b1;
            end
            PH_TYP0: begin
                elem_type = {8'h00, b};
                if (typ_code == TypeCodeExt16) begin
                    phase      = PH_TYP1;
                    header_cut = last;
                end else begin
                    header_ready = 1'b1;
                end
            end
            PH_TYP1: begin
                elem_type[15:8] = b;
                header_ready    = 1'b1;
            end
            PH_PAY: begin
                // only the first eight bytes enter the packed value
                if (pay_count < ValueBytes) value_acc[pay_count[2:0] * 8 +: 8] = b;
                done = ({1'b0, pay_count} + 17'd1) >= {1'b0, elem_len};
                r = '0;
                r.kind          = KindPayload;
                r.elem_type     = elem_type;
                r.elem_len      = elem_len;
                r.payload_byte  = b;
                r.byte_index    = pay_count;
                r.element_done  = done;
                r.element_value = done ? value_acc : 64'd0;
                r.cut_short     = last && !done;
                expected_results.push_back(r);
                pay_count = pay_count + 16'd1;
                if (done || last) phase = PH_HDR;
            end
            default: begin
                len_code = b[7:5];
                typ_code = b[4:0];
                case (len_code)
                    3'd1:    elem_len = 16'd1;
                    3'd2:    elem_len = 16'd2;
                    3'd3:    elem_len = 16'd4;
                    3'd4:    elem_len = 16'd6;
                    3'd5:    elem_len = 16'd8;
                    default: elem_len = 16'd0;
                endcase
                elem_type = (typ_code < TypeCodeExt8) ? {11'd0, typ_code} : 16'd0;
                pay_count = 16'd0;
                value_acc = 64'd0;
                if (len_code >= LenCodeExt8) begin
                    phase      = PH_LEN0;
                    header_cut = last;
                end else begin
                    length_ready = 1'b1;
                end
            end
        endcase

        // Length part finished: pull in type bytes or close the header
        if (length_ready) begin
            if (typ_code >= TypeCodeExt8) begin
                phase      = PH_TYP0;
                header_cut = last;
            end else begin
                header_ready = 1'b1;
            end
        end

        if (header_ready) begin
            pay_count = 16'd0;
            value_acc = 64'd0;
            expected_results.push_back(header_result(elem_len == 16'd0,
                                                     last && elem_len != 16'd0));
            phase = (elem_len == 16'd0 || last) ? PH_HDR : PH_PAY;
        end

        // Packet ended inside the header
        if (header_cut) begin
            expected_results.push_back(header_result(1'b0, 1'b1));
            phase = PH_HDR;
        end
    endtask

    // Compare taken results first, then predict from the taken byte
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            phase     = PH_HDR;
            len_code  = 3'd0;
            typ_code  = 5'd0;
            elem_len  = 16'd0;
            elem_type = 16'd0;
            pay_count = 16'd0;
            value_acc = 64'd0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got.kind          = i_kind;
                got.elem_type     = i_elem_type;
                got.elem_len      = i_elem_len;
                got.payload_byte  = i_payload_byte;
                got.byte_index    = i_byte_index;
                got.element_done  = i_element_done;
                got.element_value = i_element_value;
                got.cut_short     = i_cut_short;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) show_result("unexpected result:", got);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            show_result("expected:", want);
                            show_result("actual:  ", got);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) decode_byte(i_data_byte, i_packet_last);
        end
        o_mismatch_count <= mismatches;
        o_pending        <= expected_results.size();
    end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
module testbench;
    import teds_pkg::*;

    localparam int WatchdogLimit = 1000;
    localparam int StimulusBytes = 500;
    localparam int DrainCycles   = 20;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic [7:0]  data_byte   = 8'd0;
    logic        packet_last = 1'b0;
    logic        out_stall   = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic        kind;
    logic [15:0] elem_type;
    logic [15:0] elem_len;
    logic [7:0]  payload_byte;
    logic [15:0] byte_index;
    logic        element_done;
    logic [63:0] element_value;
    logic        cut_short;

    int unsigned mismatches;
    int unsigned pending;
    logic        idle_in     = 1'b1;
    logic        idle_out    = 1'b1;
    int          bytes_sent  = 0;
    int          long_left   = 1;
    int          idle_cycles = 0;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    typed_element_stream_deframer_core i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_data_byte     (data_byte),
        .i_packet_last   (packet_last),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_kind          (kind),
        .o_elem_type     (elem_type),
        .o_elem_len      (elem_len),
        .o_payload_byte  (payload_byte),
        .o_byte_index    (byte_index),
        .o_element_done  (element_done),
        .o_element_value (element_value),
        .o_cut_short     (cut_short)
    );

    deframer_result_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_data_byte      (data_byte),
        .i_packet_last    (packet_last),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_kind           (kind),
        .i_elem_type      (elem_type),
        .i_elem_len       (elem_len),
        .i_payload_byte   (payload_byte),
        .i_byte_index     (byte_index),
        .i_element_done   (element_done),
        .i_element_value  (element_value),
        .i_cut_short      (cut_short),
        .o_mismatch_count (mismatches),
        .o_pending        (pending)
    );

    function automatic logic [7:0] hdr(input logic [2:0] lc, input logic [4:0] tc);
        return {lc, tc};
    endfunction

    // Offer one byte, after a random gap when idle_in is set, and hold it until taken
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = idle_in ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        data_byte   <= b;
        packet_last <= last;
        do @(posedge clk); while (in_stall);
        bytes_sent++;
    endtask

    // Build one packet: mostly well-formed elements, some truncated, some noise
    task automatic send_packet();
        logic [7:0]  pkt[$];
        logic [2:0]  lc;
        logic [4:0]  tc;
        logic [15:0] len;
        int          style;
        int          n_elems;
        int          n_pay;
        logic        broken_tail;
        style = $urandom_range(0, 9);
        if (style == 0) begin
            repeat ($urandom_range(1, 8)) pkt.push_back(8'($urandom));
        end else begin
            n_elems = $urandom_range(1, 4);
            for (int e = 0; e < n_elems; e++) begin
                broken_tail = (style <= 2) && (e == n_elems - 1);
                lc = 3'($urandom_range(0, 7));
                case ($urandom_range(0, 3))
                    0:       tc = TypeCodeExt8;
                    1:       tc = TypeCodeExt16;
                    default: tc = 5'($urandom_range(0, 29));
                endcase
                pkt.push_back(hdr(lc, tc));
                case (lc)
                    3'd0: len = 16'd0;
                    3'd1: len = 16'd1;
                    3'd2: len = 16'd2;
                    3'd3: len = 16'd4;
                    3'd4: len = 16'd6;
                    3'd5: len = 16'd8;
                    LenCodeExt8: begin
                        len = ($urandom_range(0, 15) == 0) ? 16'($urandom_range(0, 255))
                                                            : 16'($urandom_range(0, 12));
                        pkt.push_back(len[7:0]);
                    end
                    default: begin
                        if (broken_tail) begin
                            len = 16'($urandom);
                        end else if (long_left > 0 && $urandom_range(0, 15) == 0) begin
                            len = 16'($urandom_range(256, 300));
                            long_left--;
                        end else begin
                            len = 16'($urandom_range(0, 20));
                        end
                        pkt.push_back(len[7:0]);
                        pkt.push_back(len[15:8]);
                    end
                endcase
                if (tc == TypeCodeExt8) begin
                    pkt.push_back(8'($urandom));
                end else if (tc == TypeCodeExt16) begin
                    pkt.push_back(8'($urandom));
                    pkt.push_back(8'($urandom));
                end
                n_pay = int'(len);
                // a truncated tail never needs its full length sent
                if (broken_tail && n_pay > 12) n_pay = $urandom_range(0, 12);
                repeat (n_pay) pkt.push_back(8'($urandom));
            end
            if (style <= 2) begin
                repeat ($urandom_range(0, 3)) if (pkt.size() > 1) void'(pkt.pop_back());
            end
        end
        foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
    endtask

    // Receiver: stall for a random gap before each result item while idle_out is set
    initial begin
        int hold;
        do @(posedge clk); while (!rst_n);
        forever begin
            hold = idle_out ? $urandom_range(0, 15) : 0;
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    // End the run if neither channel moves for too long
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WatchdogLimit) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // zero length element, smallest header
        send_byte(hdr(3'd0, 5'd0), 1'b0);
        // all-ones header and extended fields, payload cut by packet end
        send_byte(hdr(LenCodeExt16, TypeCodeExt16), 1'b0);
        repeat (4) send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        // one-byte extended length and type, element longer than eight bytes
        send_byte(hdr(LenCodeExt8, TypeCodeExt8), 1'b0);
        send_byte(8'd10, 1'b0);
        send_byte(8'h80, 1'b0);
        for (int k = 0; k < 10; k++) send_byte(8'($urandom), k == 9);
        // packet ends while the length byte is still owed
        send_byte(hdr(LenCodeExt8, 5'd5), 1'b1);
        // header completes on the final byte with payload still owed
        send_byte(hdr(3'd1, 5'd29), 1'b1);
        // zero length element closing a packet
        send_byte(hdr(3'd0, 5'd3), 1'b0);
        send_byte(hdr(3'd0, 5'd7), 1'b1);

        while (bytes_sent < StimulusBytes) begin
            idle_in  = ($urandom_range(0, 3) != 0);
            idle_out = ($urandom_range(0, 3) != 0);
            send_packet();
        end
        in_valid <= 1'b0;

        do @(posedge clk); while (pending != 0);
        repeat (DrainCycles) @(posedge clk);
        if (mismatches == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* typed_element_stream_deframer_core.f */
rtl/core/teds_pkg.sv
rtl/core/teds_parser.sv
rtl/core/typed_element_stream_deframer_core.sv
tb/deframer_result_checker.sv
tb/testbench.sv
